// ===== hw/rtl/met_pkg.sv =====
`default_nettype none

package met_pkg;

    localparam int DATA_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;

    typedef logic signed [DATA_BITS-1:0]   data_t;
    typedef logic signed [2*DATA_BITS-1:0] prod_t;
    typedef logic signed [2*DATA_BITS:0]   wide_t;
    typedef logic        [2*DATA_BITS:0]   mag_t;
    typedef logic        [ITER_BITS-1:0]   iter_t;

    // clamp a wide signed value into the datapath range
    function automatic data_t sat_data(input wide_t x);
        data_t r;
        if (x[2*DATA_BITS:DATA_BITS-1] == '0 || x[2*DATA_BITS:DATA_BITS-1] == '1)
        begin
            r = x[DATA_BITS-1:0];
        end
        else if (x[2*DATA_BITS])
        begin
            r = {1'b1, {(DATA_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// mandelbrot escape-time unit
// input channel (s_axis): one item is a point c, c_re in tdata[31:0] and
//   c_im in tdata[63:32], both signed q4.28
// output channel (m_axis): iterations in tdata[15:0], reached_limit in tuser
// config port: apb-style, max_iter at byte address 0 (low 16 bits of pwdata),
//   reset value 5000; write only while the unit is idle
// one shared 32x32 signed multiplier runs z = z*z + c; each iteration is one
//   update of z and three products (re*re, im*im, re*im), the escape compare
//   overlapping the last product
// a point inside the set runs max_iter iterations before its result is
//   loaded into the output register
// s_axis_tready is high only while no point is in work; one point at a time,
//   so a new point is taken only once the last result has left the sequencer
// the finished result sits in the output register until taken; a stalled
//   receiver holds the next result back, and the unit stays busy meanwhile
// reset clears the sequencer and the output valid, and restores max_iter
`default_nettype none

module mandelbrot_escape_time
    import met_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [2*DATA_BITS-1:0] s_axis_tdata,   // c_re, c_im
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [ITER_BITS-1:0]        m_axis_tdata,   // iterations
    output logic                        m_axis_tuser,   // reached_limit
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_MRR  = 3'd2;
    localparam logic [2:0] ST_MII  = 3'd3;
    localparam logic [2:0] ST_MRI  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam mag_t ESC_THR = mag_t'(1) << (2*FRAC_BITS + 2);

    logic [2:0] state_reg, state_next;
    iter_t      max_iter_reg;
    iter_t      k_reg, k_next;
    logic       lim_reg, lim_next;
    data_t      c_re_reg, c_im_reg;
    data_t      re_reg, im_reg;
    prod_t      rr_reg, ii_reg, ri_reg;
    logic       out_valid_reg, out_valid_next;
    iter_t      out_iter_reg;
    logic       out_lim_reg;

    data_t mul_a, mul_b;
    prod_t mul_p;
    prod_t diff_re, sh_re, sh_im;
    data_t new_re, new_im;
    mag_t  esc_sum;
    logic  escaped;
    logic  last_step;
    logic  in_take;
    logic  out_load;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-ITER_BITS){1'b0}}, max_iter_reg};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_iter_reg;
    assign m_axis_tuser  = out_lim_reg;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_MRR:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
            ST_MII:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            default:
            begin
                mul_a = re_reg;
                mul_b = im_reg;
            end
        endcase
    end

    assign mul_p = prod_t'(mul_a) * prod_t'(mul_b);

    assign diff_re = rr_reg - ii_reg;
    assign sh_re   = diff_re >>> FRAC_BITS;
    assign sh_im   = ri_reg >>> (FRAC_BITS - 1);
    assign new_re  = sat_data(wide_t'(sh_re) + wide_t'(c_re_reg));
    assign new_im  = sat_data(wide_t'(sh_im) + wide_t'(c_im_reg));

    // squares are never negative, so the sum fits unsigned
    assign esc_sum   = mag_t'(unsigned'(rr_reg)) + mag_t'(unsigned'(ii_reg));
    assign escaped   = (esc_sum >= ESC_THR);
    assign last_step = (k_reg == max_iter_reg - iter_t'(1));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        lim_next       = lim_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (max_iter_reg == '0)
                    begin
                        k_next     = max_iter_reg - iter_t'(1);
                        lim_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                state_next = ST_MRR;
            end
            ST_MRR:
            begin
                state_next = ST_MII;
            end
            ST_MII:
            begin
                state_next = ST_MRI;
            end
            ST_MRI:
            begin
                if (escaped)
                begin
                    lim_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (last_step)
                begin
                    lim_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + iter_t'(1);
                    state_next = ST_UPD;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_iter_reg  <= iter_t'(5000);
            k_reg         <= '0;
            lim_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            lim_reg       <= lim_next;
            if (cfg_wr)
            begin
                max_iter_reg <= pwdata[ITER_BITS-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            c_re_reg <= s_axis_tdata[DATA_BITS-1:0];
            c_im_reg <= s_axis_tdata[2*DATA_BITS-1:DATA_BITS];
            rr_reg   <= '0;
            ii_reg   <= '0;
            ri_reg   <= '0;
        end
        if (state_reg == ST_UPD)
        begin
            re_reg <= new_re;
            im_reg <= new_im;
        end
        if (state_reg == ST_MRR)
        begin
            rr_reg <= mul_p;
        end
        if (state_reg == ST_MII)
        begin
            ii_reg <= mul_p;
        end
        if (state_reg == ST_MRI)
        begin
            ri_reg <= mul_p;
        end
        if (out_load)
        begin
            out_iter_reg <= k_reg;
            out_lim_reg  <= lim_reg;
        end
    end

`ifndef SYNTHESIS
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD || state_reg == ST_MRR || state_reg == ST_MII
            || state_reg == ST_MRI) |-> (k_reg < max_iter_reg))
        else $error("iteration count beyond limit");

    a_limit_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == max_iter_reg - iter_t'(1)))
        else $error("limit result does not equal max_iter minus one");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after taking an item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import met_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned REG_MAX_ITER = 0;
    localparam logic [2:0]  ADDR_MAX_ITER = 3'd0;
    localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;

    localparam data_t Q_ZERO = 32'sh0000_0000;
    localparam data_t Q_ONE  = 32'sh1000_0000;
    localparam data_t Q_1_5  = 32'sh1800_0000;
    localparam data_t Q_TWO  = 32'sh2000_0000;
    localparam data_t Q_MAX  = 32'sh7FFF_FFFF;
    localparam data_t Q_MIN  = 32'sh8000_0000;

    typedef logic signed [2*DATA_BITS+3:0] acc_t;

    typedef struct packed {
        iter_t iterations;
        logic  reached_limit;
    } escape_t;

    class escape_board;
        iter_t       limit;
        escape_t     expected_q[$];
        int unsigned errors;

        function new();
            limit  = 16'd5000;
            errors = 0;
        endfunction

        function void set_register(int unsigned index, logic [31:0] value);
            if (index == REG_MAX_ITER)
            begin
                limit = value[ITER_BITS-1:0];
            end
        endfunction

        function acc_t clamp(acc_t v);
            acc_t top;
            acc_t bottom;
            top    = (68'sd1 <<< (DATA_BITS-1)) - 68'sd1;
            bottom = -top - 68'sd1;
            if (v > top)
            begin
                return top;
            end
            if (v < bottom)
            begin
                return bottom;
            end
            return v;
        endfunction

        // iterate z = z*z + c from zero until |z|^2 >= 4 or the limit runs out
        function escape_t escape_of(data_t c_re, data_t c_im);
            acc_t        re;
            acc_t        im;
            acc_t        cre;
            acc_t        cim;
            acc_t        nre;
            acc_t        nim;
            acc_t        thresh;
            int unsigned step;
            bit          escaped;
            escape_t     r;
            thresh  = 68'sd1 <<< (2*FRAC_BITS+2);
            cre     = c_re;
            cim     = c_im;
            re      = 0;
            im      = 0;
            step    = 0;
            escaped = 0;
            while (!escaped && step < limit)
            begin
                nre = ((re*re - im*im) >>> FRAC_BITS) + cre;
                nim = ((re*im) >>> (FRAC_BITS-1)) + cim;
                re  = clamp(nre);
                im  = clamp(nim);
                if (re*re + im*im >= thresh)
                begin
                    escaped = 1;
                end
                else
                begin
                    step++;
                end
            end
            if (escaped)
            begin
                r.iterations    = iter_t'(step);
                r.reached_limit = 1'b0;
            end
            else
            begin
                r.iterations    = limit - 16'd1;
                r.reached_limit = 1'b1;
            end
            return r;
        endfunction

        function void note_point(data_t c_re, data_t c_im);
            expected_q.push_back(escape_of(c_re, c_im));
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endfunction

        function void check_result(iter_t got_iter, logic got_flag);
            escape_t want;
            if (expected_q.size() == 0)
            begin
                complain($sformatf("result %0d limit %0b with no point waiting",
                                   got_iter, got_flag));
                return;
            end
            want = expected_q.pop_front();
            if (got_iter !== want.iterations)
            begin
                complain($sformatf("iterations %0d, expected %0d",
                                   got_iter, want.iterations));
            end
            if (got_flag !== want.reached_limit)
            begin
                complain($sformatf("reached_limit %0b, expected %0b",
                                   got_flag, want.reached_limit));
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [2*DATA_BITS-1:0] s_axis_tdata;   // c_re, c_im
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [ITER_BITS-1:0]   m_axis_tdata;   // iterations
    logic                   m_axis_tuser;   // reached_limit
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    escape_board board;
    int unsigned send_idle;
    int unsigned recv_idle;
    bit          hold_rx;
    int unsigned cycles;

    mandelbrot_escape_time u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = !hold_rx && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_point(input data_t c_re, input data_t c_im);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {c_im, c_re};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        board.note_point(c_re, c_im);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] got;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        board.set_register(addr >> 2, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr == ADDR_MAX_ITER)
        begin
            @(negedge clk);
            psel   = 1'b1;
            pwrite = 1'b0;
            @(negedge clk);
            penable = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!pready);
            got = prdata;
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            if (got !== {16'h0000, board.limit})
            begin
                board.complain($sformatf("max_iter read %h, expected %h",
                                         got, {16'h0000, board.limit}));
            end
        end
    endtask

    // mostly points around the set, some deep inside, some anywhere
    function automatic logic [63:0] random_point();
        int unsigned pick;
        int          re_v;
        int          im_v;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            re_v = int'($urandom_range(671088640)) - 536870912;
            im_v = int'($urandom_range(671088640)) - 335544320;
        end
        else if (pick < 75)
        begin
            re_v = int'($urandom_range(100000000)) - 50000000;
            im_v = int'($urandom_range(100000000)) - 50000000;
        end
        else
        begin
            re_v = $urandom;
            im_v = $urandom;
        end
        return {im_v, re_v};
    endfunction

    task automatic run_random(input int unsigned count);
        logic [63:0] pt;
        repeat (count)
        begin
            pt = random_point();
            send_point(pt[31:0], pt[63:32]);
        end
    endtask

    initial
    begin
        board         = new();
        cycles        = 0;
        hold_rx       = 1'b0;
        send_idle     = 15;
        recv_idle     = 50;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset limit of 5000
        send_point(Q_ZERO, Q_ZERO);
        send_point(-Q_TWO, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        send_point(-Q_ONE, Q_ZERO);
        send_point(Q_ZERO, Q_ONE);
        send_point(-32'sh0C00_0000, 32'sh0199_999A);
        send_point(32'sh0428_F5C3, Q_ZERO);
        drain();

        // write to an unmapped register leaves the limit alone
        reg_write(ADDR_UNMAPPED, 32'hDEAD_0003);
        send_point(-Q_ONE, Q_ZERO);
        drain();

        // limit of zero runs no step
        reg_write(ADDR_MAX_ITER, 32'd0);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_MAX, Q_MIN);
        drain();

        reg_write(ADDR_MAX_ITER, 32'd1);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_ZERO, -Q_TWO);
        send_point(Q_1_5, Q_ZERO);
        drain();

        // escape on the last step
        reg_write(ADDR_MAX_ITER, 32'd2);
        send_point(Q_1_5, Q_ZERO);
        drain();

        reg_write(ADDR_MAX_ITER, 32'hA5A5_FFFF);
        send_point(Q_ZERO, Q_ZERO);
        send_point(32'sh0428_F5C3, Q_ZERO);
        send_point(Q_MIN, Q_MIN);
        drain();

        reg_write(ADDR_MAX_ITER, 32'(8 + $urandom_range(56)));
        run_random(32);
        drain();

        send_idle = 50;
        recv_idle = 15;
        reg_write(ADDR_MAX_ITER, 32'(100 + $urandom_range(200)));
        run_random(32);
        drain();

        send_idle = 0;
        recv_idle = 0;
        reg_write(ADDR_MAX_ITER, 32'(1 + $urandom_range(63)));
        fork
            begin
                hold_rx = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rx = 1'b0;
            end
        join_none
        run_random(32);
        drain();

        repeat (16) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/met_pkg.sv
hw/rtl/mandelbrot_escape_time.sv
tb/tb.sv
